### rtl/core/hbd_pkg.sv
// ----------------------------------------------------------------------------
// hbd_pkg
// Shared types, field layout and helpers of the bit-serial Huffman decoder.
// ----------------------------------------------------------------------------
package hbd_pkg;

   localparam int SYM_COUNT     = 256;
   localparam int SYM_W         = $clog2(SYM_COUNT);
   localparam int SCAN_W        = $clog2(SYM_COUNT + 1);
   localparam int MAX_CODE_BITS = 64;
   localparam int CODE_W        = 64;
   localparam int LEN_W         = 7;
   localparam int SYMIN_W       = 8;
   localparam int BYTE_W        = 8;
   localparam int CNT_W         = 4;
   localparam int MODE_W        = 2;

   // Request tdata layout, lowest bit first.
   localparam int SYMIN_LSB  = 0;
   localparam int CODE_LSB   = SYMIN_LSB + SYMIN_W;
   localparam int LEN_LSB    = CODE_LSB + CODE_W;
   localparam int BYTE_LSB   = LEN_LSB + LEN_W;
   localparam int CNT_LSB    = BYTE_LSB + BYTE_W;
   localparam int REQ_BITS   = CNT_LSB + CNT_W;
   localparam int REQ_DATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_W = 8;

   typedef enum logic [MODE_W-1:0] {
      MODE_LOAD  = 2'd0,
      MODE_BYTE  = 2'd1,
      MODE_FINAL = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_BIT,
      ST_SCAN,
      ST_DECIDE,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic [LEN_W-1:0]  len;
      logic [CODE_W-1:0] code;
   } entry_type;

   typedef struct packed {
      logic             clear;
      logic             eval;
      logic [SYM_W-1:0] sym;
   } match_ctl_type;

   typedef struct packed {
      logic             hit;
      logic [SYM_W-1:0] sym;
      logic             prefix;
   } match_sts_type;

   function automatic logic [CODE_W-1:0] code_mask(input logic [LEN_W-1:0] len);
      logic [CODE_W-1:0] m;
      if (len >= LEN_W'(CODE_W)) begin
         m = '1;
      end else begin
         m = (CODE_W'(1) << len) - CODE_W'(1);
      end
      return m;
   endfunction

endpackage

### rtl/core/hbd_ram.sv
// ----------------------------------------------------------------------------
// hbd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module hbd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/hbd_match.sv
// ----------------------------------------------------------------------------
// hbd_match
// Compare unit: checks one stored code per cycle against the accumulated
// code and keeps the sweep result (first exact hit, any longer prefix).
// ----------------------------------------------------------------------------
module hbd_match (
   input  logic                         clock,
   input  logic                         reset,
   input  hbd_pkg::match_ctl_type       ctl,
   input  hbd_pkg::entry_type           entry,
   input  logic [hbd_pkg::CODE_W-1:0]   partial_code,
   input  logic [hbd_pkg::LEN_W-1:0]    partial_len,
   output hbd_pkg::match_sts_type       sts
);
   import hbd_pkg::*;

   logic [LEN_W-1:0]  diff;
   logic [CODE_W-1:0] shifted;
   logic              hit_now;
   logic              pref_now;
   logic              hit_ff, hit_in;
   logic [SYM_W-1:0]  sym_ff, sym_in;
   logic              prefix_ff, prefix_in;

   always_comb begin
      diff     = entry.len - partial_len;
      shifted  = entry.code >> diff;
      hit_now  = (entry.len == partial_len) && (entry.code == partial_code);
      pref_now = (entry.len > partial_len) && (shifted == partial_code);
   end

   always_comb begin
      hit_in    = hit_ff;
      sym_in    = sym_ff;
      prefix_in = prefix_ff;
      if (ctl.clear) begin
         hit_in    = 1'b0;
         prefix_in = 1'b0;
      end else if (ctl.eval) begin
         // The sweep runs from symbol zero up, so the first hit is the lowest.
         if (hit_now && !hit_ff) begin
            hit_in = 1'b1;
            sym_in = ctl.sym;
         end
         if (pref_now) begin
            prefix_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff    <= 1'b0;
         prefix_ff <= 1'b0;
      end else begin
         hit_ff    <= hit_in;
         prefix_ff <= prefix_in;
      end
      sym_ff <= sym_in;
   end

   assign sts.hit    = hit_ff;
   assign sts.sym    = sym_ff;
   assign sts.prefix = prefix_ff;

endmodule

### rtl/core/huffman_table_bit_decoder.sv
// ----------------------------------------------------------------------------
// huffman_table_bit_decoder
// Bit-serial Huffman decoder with a loadable per-symbol code store.
// ----------------------------------------------------------------------------
// After reset the block clears all 256 entries of its code store and is not
// ready meanwhile. A table load transaction writes the code store directly
// from the idle state. Each data bit is first shifted into the accumulated
// code; then all 256 stored entries are swept through the single read port of
// the code store into the compare unit, and a decide step follows. The sweep
// of the code store is what sets the time a byte takes. Results are held one
// deep so that the last result of an item can carry tlast; a stalled result
// port stalls the decoder.
module huffman_table_bit_decoder (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // symbol_in[7:0], code_bits[71:8], code_length[78:72], data_byte[86:79],
   // bit_count[90:87], zero fill above
   input  logic [hbd_pkg::REQ_DATA_W-1:0]   req_tdata,
   // mode[1:0]
   input  logic [hbd_pkg::MODE_W-1:0]       req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // symbol_out[7:0]
   output logic [hbd_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // code_error[0]
   output logic [0:0]                       rsp_tuser,
   output logic                             rsp_tlast
);
   import hbd_pkg::*;

   state_type         state_ff, state_in;
   logic [SCAN_W-1:0] cnt_ff, cnt_in;
   logic [CODE_W-1:0] partial_code_ff, partial_code_in;
   logic [LEN_W-1:0]  partial_len_ff, partial_len_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic [CNT_W-1:0]  bits_left_ff, bits_left_in;
   logic              final_ff, final_in;
   logic              rd_valid_ff, rd_valid_in;
   logic [SYM_W-1:0]  rd_sym_ff, rd_sym_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [SYM_W-1:0]  pend_sym_ff, pend_sym_in;
   logic              pend_err_ff, pend_err_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SYM_W-1:0]  rsp_sym_ff, rsp_sym_in;
   logic              rsp_err_ff, rsp_err_in;
   logic              rsp_last_ff, rsp_last_in;

   mode_type           in_mode;
   logic [SYMIN_W-1:0] in_sym;
   logic [CODE_W-1:0]  in_code;
   logic [LEN_W-1:0]   in_len;
   logic [BYTE_W-1:0]  in_byte;
   logic [CNT_W-1:0]   in_cnt;
   logic [CNT_W-1:0]   in_count;
   logic               sym_ok;
   logic               req_fire;
   logic               out_free;
   logic               res_now;
   logic               decide_go;
   logic               rsp_push;
   logic               scan_more;

   logic               ram_we;
   logic [SYM_W-1:0]   ram_waddr;
   entry_type          ram_wdata;
   logic               ram_re;
   logic [SYM_W-1:0]   ram_raddr;
   logic [$bits(entry_type)-1:0] ram_rdata;
   entry_type          entry;

   match_ctl_type      mctl;
   match_sts_type      msts;

   assign in_mode  = mode_type'(req_tuser);
   assign in_sym   = req_tdata[SYMIN_LSB +: SYMIN_W];
   assign in_code  = req_tdata[CODE_LSB +: CODE_W];
   assign in_len   = req_tdata[LEN_LSB +: LEN_W];
   assign in_byte  = req_tdata[BYTE_LSB +: BYTE_W];
   assign in_cnt   = req_tdata[CNT_LSB +: CNT_W];
   assign in_count = ((in_mode == MODE_BYTE) || (in_cnt > CNT_W'(BYTE_W))) ?
                     CNT_W'(BYTE_W) : in_cnt;
   assign sym_ok   = ({1'b0, in_sym} < (SYMIN_W + 1)'(SYM_COUNT));

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign res_now    = msts.hit || !msts.prefix;
   assign decide_go  = !(res_now && pend_valid_ff && !out_free);
   assign scan_more  = (cnt_ff < SCAN_W'(SYM_COUNT));
   assign entry      = entry_type'(ram_rdata);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (cnt_ff == SCAN_W'(SYM_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire && ((in_mode == MODE_BYTE) || (in_mode == MODE_FINAL))) begin
               state_in = (in_count == '0) ? ST_FLUSH : ST_BIT;
            end
         end
         ST_BIT: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (!scan_more) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (decide_go) begin
               state_in = (bits_left_ff == '0) ? ST_FLUSH : ST_BIT;
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff || out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath and control.
   always_comb begin
      cnt_in          = cnt_ff;
      partial_code_in = partial_code_ff;
      partial_len_in  = partial_len_ff;
      byte_in         = byte_ff;
      bits_left_in    = bits_left_ff;
      final_in        = final_ff;
      rd_valid_in     = 1'b0;
      rd_sym_in       = rd_sym_ff;
      pend_valid_in   = pend_valid_ff;
      pend_sym_in     = pend_sym_ff;
      pend_err_in     = pend_err_ff;
      rsp_push        = 1'b0;
      rsp_sym_in      = rsp_sym_ff;
      rsp_err_in      = rsp_err_ff;
      rsp_last_in     = rsp_last_ff;
      ram_we          = 1'b0;
      ram_waddr       = in_sym[SYM_W-1:0];
      ram_wdata       = '0;
      ram_re          = 1'b0;
      ram_raddr       = cnt_ff[SYM_W-1:0];
      mctl.clear      = 1'b0;
      mctl.eval       = rd_valid_ff;
      mctl.sym        = rd_sym_ff;

      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = cnt_ff[SYM_W-1:0];
            cnt_in    = cnt_ff + SCAN_W'(1);
         end
         ST_IDLE: begin
            if (req_fire) begin
               case (in_mode)
                  MODE_LOAD: begin
                     ram_we = sym_ok;
                     // An overlong length stores the symbol as absent.
                     if (in_len <= LEN_W'(MAX_CODE_BITS)) begin
                        ram_wdata.len  = in_len;
                        ram_wdata.code = in_code & code_mask(in_len);
                     end
                  end
                  MODE_BYTE, MODE_FINAL: begin
                     byte_in      = in_byte;
                     bits_left_in = in_count;
                     final_in     = (in_mode == MODE_FINAL);
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_BIT: begin
            partial_code_in = {partial_code_ff[CODE_W-2:0], byte_ff[BYTE_W-1]};
            partial_len_in  = partial_len_ff + LEN_W'(1);
            byte_in         = byte_ff << 1;
            bits_left_in    = bits_left_ff - CNT_W'(1);
            cnt_in          = '0;
            mctl.clear      = 1'b1;
         end
         ST_SCAN: begin
            ram_re      = scan_more;
            rd_valid_in = scan_more;
            rd_sym_in   = cnt_ff[SYM_W-1:0];
            if (scan_more) begin
               cnt_in = cnt_ff + SCAN_W'(1);
            end
         end
         ST_DECIDE: begin
            if (decide_go && res_now) begin
               // The held result is not the item's last one; pass it on.
               if (pend_valid_ff) begin
                  rsp_push    = 1'b1;
                  rsp_sym_in  = pend_sym_ff;
                  rsp_err_in  = pend_err_ff;
                  rsp_last_in = 1'b0;
               end
               pend_valid_in   = 1'b1;
               pend_sym_in     = msts.hit ? msts.sym : '0;
               pend_err_in     = !msts.hit;
               partial_code_in = '0;
               partial_len_in  = '0;
            end
         end
         ST_FLUSH: begin
            if (final_ff) begin
               partial_code_in = '0;
               partial_len_in  = '0;
            end
            if (pend_valid_ff && out_free) begin
               rsp_push      = 1'b1;
               rsp_sym_in    = pend_sym_ff;
               rsp_err_in    = pend_err_ff;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
            end
         end
         default: begin
         end
      endcase

      rsp_valid_in = rsp_push || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         cnt_ff          <= '0;
         partial_code_ff <= '0;
         partial_len_ff  <= '0;
         bits_left_ff    <= '0;
         final_ff        <= 1'b0;
         rd_valid_ff     <= 1'b0;
         pend_valid_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         cnt_ff          <= cnt_in;
         partial_code_ff <= partial_code_in;
         partial_len_ff  <= partial_len_in;
         bits_left_ff    <= bits_left_in;
         final_ff        <= final_in;
         rd_valid_ff     <= rd_valid_in;
         pend_valid_ff   <= pend_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      byte_ff     <= byte_in;
      rd_sym_ff   <= rd_sym_in;
      pend_sym_ff <= pend_sym_in;
      pend_err_ff <= pend_err_in;
      rsp_sym_ff  <= rsp_sym_in;
      rsp_err_ff  <= rsp_err_in;
      rsp_last_ff <= rsp_last_in;
   end

   hbd_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (SYM_COUNT)
   ) u_code_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   hbd_match u_match (
      .clock        (clock),
      .reset        (reset),
      .ctl          (mctl),
      .entry        (entry),
      .partial_code (partial_code_ff),
      .partial_len  (partial_len_ff),
      .sts          (msts)
   );

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = RSP_DATA_W'(rsp_sym_ff);
   assign rsp_tuser[0] = rsp_err_ff;
   assign rsp_tlast    = rsp_last_ff;

   // No held result may be left behind when the block is ready for a new item.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_valid_ff)
      else $error("held result left over at idle");

   // Every code length that reaches the maximum is resolved by hit or error.
   assert property (@(posedge clock) disable iff (reset)
      partial_len_ff <= LEN_W'(MAX_CODE_BITS))
      else $error("accumulated code grew beyond the longest code");

   // Only the end-of-item step may mark a result as the last one.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_push && rsp_last_in) |-> (state_ff == ST_FLUSH))
      else $error("last result pushed outside end of item");

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bit-serial Huffman decoder. A directed opening
// covers empty, long, masked, duplicate, absent and overlong table entries,
// the final partial byte and the unused mode. Random prefix-free code sets
// with encoded streams follow, mixed with noise, under varying backpressure.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import hbd_pkg::*;

   localparam int ITEM_TARGET = 230;
   localparam int HOLD_CYCLES = 6000;

   typedef struct {
      logic [SYM_W-1:0] sym;
      logic             err;
      logic             last;
   } symbol_result_type;

   // Tracks the code store and the accumulated code, and keeps the decoded
   // symbols that are still due from the block.
   class huffman_tracker;
      logic [CODE_W-1:0] code_store [SYM_COUNT];
      logic [LEN_W-1:0]  len_store [SYM_COUNT];
      logic [CODE_W-1:0] acc_code;
      logic [LEN_W-1:0]  acc_len;
      symbol_result_type expected_symbols [$];
      int                errors;

      function new();
         foreach (code_store[i]) begin
            code_store[i] = '0;
            len_store[i]  = '0;
         end
         acc_code = '0;
         acc_len  = '0;
         errors   = 0;
      endfunction

      task report(input string msg);
         $display("MISMATCH at %0t: %s", $time, msg);
         errors++;
      endtask

      function void absorb_item(input mode_type m, input logic [SYMIN_W-1:0] sym,
                                input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len,
                                input logic [BYTE_W-1:0] data, input logic [CNT_W-1:0] cnt);
         symbol_result_type found [$];
         symbol_result_type r;
         int                nbits;
         bit                hit;
         bit                prefix;
         logic [SYM_W-1:0]  hit_sym;
         case (m)
            MODE_LOAD: begin
               if (len > MAX_CODE_BITS) begin
                  code_store[sym] = '0;
                  len_store[sym]  = '0;
               end else begin
                  code_store[sym] = code & ~({CODE_W{1'b1}} << len);
                  len_store[sym]  = len;
               end
            end
            MODE_BYTE, MODE_FINAL: begin
               nbits = (m == MODE_BYTE || cnt > 8) ? 8 : int'(cnt);
               for (int i = 0; i < nbits; i++) begin
                  acc_code = {acc_code[CODE_W-2:0], data[7-i]};
                  acc_len++;
                  hit = 0;
                  hit_sym = '0;
                  // The lowest symbol number wins when several share a code.
                  for (int s = 0; s < SYM_COUNT && !hit; s++) begin
                     if (len_store[s] == acc_len && code_store[s] == acc_code) begin
                        hit = 1;
                        hit_sym = SYM_W'(s);
                     end
                  end
                  prefix = 0;
                  if (!hit) begin
                     for (int s = 0; s < SYM_COUNT; s++) begin
                        if (len_store[s] > acc_len &&
                            (code_store[s] >> (len_store[s] - acc_len)) == acc_code) begin
                           prefix = 1;
                        end
                     end
                  end
                  if (hit || !prefix) begin
                     r.sym  = hit ? hit_sym : '0;
                     r.err  = !hit;
                     r.last = 1'b0;
                     found.insert(found.size(), r);
                     acc_code = '0;
                     acc_len  = '0;
                  end
               end
               // Bits of an unfinished code are dropped at the end of a stream.
               if (m == MODE_FINAL) begin
                  acc_code = '0;
                  acc_len  = '0;
               end
               if (found.size() > 0) begin
                  found[found.size()-1].last = 1'b1;
               end
               foreach (found[i]) begin
                  expected_symbols.insert(expected_symbols.size(), found[i]);
               end
            end
            default: begin
            end
         endcase
      endfunction

      task check_symbol(input logic [SYM_W-1:0] sym, input logic err, input logic last);
         symbol_result_type want;
         if (expected_symbols.size() == 0) begin
            report($sformatf("unexpected symbol %0d code_error %b last %b", sym, err, last));
         end else begin
            want = expected_symbols.pop_front();
            if (sym !== want.sym || err !== want.err || last !== want.last) begin
               report($sformatf("got symbol %0d code_error %b last %b, want %0d %b %b",
                                sym, err, last, want.sym, want.err, want.last));
            end
         end
      endtask
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [MODE_W-1:0]     req_tuser  = MODE_NONE;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [0:0]            rsp_tuser;
   logic                  rsp_tlast;

   huffman_tracker      sb = new();
   logic [SYM_W-1:0]    live_syms [$];
   int                  items_sent      = 0;
   int                  sender_idle_pct = 0;
   int                  rsp_stall_pct   = 0;
   bit                  hold_trigger    = 0;
   bit                  rsp_hold        = 0;

   huffman_table_bit_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #2 clock = ~clock;

   always @(negedge clock) begin
      rsp_tready <= !rsp_hold && ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_symbol(rsp_tdata, rsp_tuser[0], rsp_tlast);
      end
   end

   // Long hold-off of the result port while the sender keeps offering.
   initial begin
      wait (hold_trigger);
      rsp_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold = 1'b0;
   end

   initial begin
      #16_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   task automatic send_item(input mode_type m, input logic [SYMIN_W-1:0] sym,
                            input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len,
                            input logic [BYTE_W-1:0] data, input logic [CNT_W-1:0] cnt);
      logic [REQ_DATA_W-1:0] word;
      word = '0;
      word[SYMIN_LSB +: SYMIN_W] = sym;
      word[CODE_LSB +: CODE_W]   = code;
      word[LEN_LSB +: LEN_W]     = len;
      word[BYTE_LSB +: BYTE_W]   = data;
      word[CNT_LSB +: CNT_W]     = cnt;
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      req_tuser  <= m;
      do @(posedge clock); while (!req_tready);
      sb.absorb_item(m, sym, code, len, data, cnt);
      if (m == MODE_LOAD && len != 0 && len <= MAX_CODE_BITS) begin
         live_syms.insert(live_syms.size(), sym);
      end
      if (m != MODE_NONE) begin
         items_sent++;
      end
   endtask

   task automatic load_entry(input logic [SYMIN_W-1:0] sym, input logic [CODE_W-1:0] code,
                             input logic [LEN_W-1:0] len);
      send_item(MODE_LOAD, sym, code, len, BYTE_W'($urandom), CNT_W'($urandom));
   endtask

   task automatic feed_byte(input mode_type m, input logic [BYTE_W-1:0] data,
                            input logic [CNT_W-1:0] cnt);
      send_item(m, SYMIN_W'($urandom), {$urandom, $urandom}, LEN_W'($urandom), data, cnt);
   endtask

   initial begin
      logic [CODE_W-1:0] leaf_code [16];
      int                leaf_len [16];
      logic [SYM_W-1:0]  sym_of [16];
      bit                taken [SYM_COUNT];
      bit                stream_bits [$];
      logic [BYTE_W-1:0] byte_val;
      logic [CODE_W-1:0] mask;
      int                k, nleaf, nsym, p, e, s, rem;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed opening. With an empty table every bit is an error.
      feed_byte(MODE_BYTE, 8'hA5, 4'd0);
      load_entry(8'd255, '1, 7'd64);
      load_entry(8'd0, 64'hFFFF_FFFF_FFFF_FFFE, 7'd1);
      load_entry(8'd1, 64'h5555_5555_5555_5556, 7'd2);
      load_entry(8'd2, 64'h0000_0000_0000_0006, 7'd3);
      feed_byte(MODE_BYTE, 8'h00, 4'd0);
      feed_byte(MODE_BYTE, 8'hB6, 4'd0);
      // Sixty-four ones reach the longest code only on the eighth byte.
      repeat (8) feed_byte(MODE_BYTE, 8'hFF, 4'd0);
      load_entry(8'd3, 64'h6, 7'd3);
      feed_byte(MODE_FINAL, 8'hC0, 4'd3);
      load_entry(8'd2, 64'h6, 7'd65);
      feed_byte(MODE_FINAL, 8'hDF, 4'd3);
      load_entry(8'd1, 64'h2, 7'd127);
      feed_byte(MODE_BYTE, 8'h80, 4'd0);
      feed_byte(MODE_FINAL, 8'hFF, 4'd15);
      feed_byte(MODE_FINAL, 8'h0F, 4'd9);
      feed_byte(MODE_FINAL, 8'h00, 4'd0);
      feed_byte(MODE_NONE, 8'h5A, 4'd8);
      load_entry(8'd255, '1, 7'd0);
      feed_byte(MODE_BYTE, 8'hFF, 4'd0);

      while (items_sent < ITEM_TARGET) begin
         if (items_sent >= 175) begin
            sender_idle_pct = 31;
            rsp_stall_pct   = 31;
         end else if (items_sent >= 125) begin
            sender_idle_pct = 0;
            rsp_stall_pct   = 50;
            hold_trigger    = 1;
         end else if (items_sent >= 75) begin
            sender_idle_pct = 50;
            rsp_stall_pct   = 0;
         end

         // Retire the previous code set, sometimes through an overlong length.
         foreach (live_syms[i]) begin
            load_entry(live_syms[i], {$urandom, $urandom},
                       ($urandom_range(3) == 0) ? LEN_W'($urandom_range(65, 127)) : '0);
         end
         live_syms.delete();

         // Grow a random prefix-free code by splitting leaves.
         k = $urandom_range(2, 10);
         nleaf = 1;
         leaf_code[0] = '0;
         leaf_len[0]  = 0;
         while (nleaf < k) begin
            p = $urandom_range(nleaf - 1);
            leaf_code[nleaf] = (leaf_code[p] << 1) | 64'd1;
            leaf_len[nleaf]  = leaf_len[p] + 1;
            leaf_code[p]     = leaf_code[p] << 1;
            leaf_len[p]++;
            nleaf++;
         end
         if ($urandom_range(5) == 0) begin
            p = $urandom_range(nleaf - 1);
            e = $urandom_range(1, MAX_CODE_BITS - leaf_len[p]);
            mask = ~({CODE_W{1'b1}} << e);
            leaf_code[p] = (leaf_code[p] << e) | ({$urandom, $urandom} & mask);
            leaf_len[p] += e;
         end
         // Leaving out the last leaf makes the code incomplete.
         nsym = ($urandom_range(3) == 0) ? nleaf - 1 : nleaf;

         foreach (taken[i]) begin
            taken[i] = 0;
         end
         for (int j = 0; j < nsym; j++) begin
            do s = $urandom_range(SYM_COUNT - 1); while (taken[s]);
            taken[s]  = 1;
            sym_of[j] = SYM_W'(s);
            mask = ~({CODE_W{1'b1}} << leaf_len[j]);
            load_entry(sym_of[j], ({$urandom, $urandom} & ~mask) | leaf_code[j],
                       LEN_W'(leaf_len[j]));
         end
         if ($urandom_range(4) == 0) begin
            p = $urandom_range(nsym - 1);
            do s = $urandom_range(SYM_COUNT - 1); while (taken[s]);
            taken[s] = 1;
            load_entry(SYM_W'(s), leaf_code[p], LEN_W'(leaf_len[p]));
         end

         do begin
            p = $urandom_range(nsym - 1);
            for (int j = leaf_len[p] - 1; j >= 0; j--) begin
               stream_bits.insert(stream_bits.size(), leaf_code[p][j]);
            end
         end while (stream_bits.size() < 40 && $urandom_range(7) != 0);

         while (stream_bits.size() >= 8) begin
            for (int j = 0; j < 8; j++) begin
               byte_val[7-j] = stream_bits.pop_front();
            end
            feed_byte(MODE_BYTE, byte_val, CNT_W'($urandom));
         end
         rem = stream_bits.size();
         if (rem > 0) begin
            byte_val = BYTE_W'($urandom);
            for (int j = 0; j < rem; j++) begin
               byte_val[7-j] = stream_bits.pop_front();
            end
            feed_byte(MODE_FINAL, byte_val, CNT_W'(rem));
         end else if ($urandom_range(1) == 1) begin
            feed_byte(MODE_FINAL, BYTE_W'($urandom), 4'd0);
         end

         // Noise: arbitrary transactions of any mode against the live table.
         if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(1, 4)) begin
               send_item(mode_type'($urandom_range(3)), SYMIN_W'($urandom),
                         {$urandom, $urandom}, LEN_W'($urandom), BYTE_W'($urandom),
                         CNT_W'($urandom));
            end
         end
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.expected_symbols.size() != 0) @(posedge clock);
      repeat (2500) @(posedge clock);
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/core/hbd_pkg.sv
rtl/core/hbd_ram.sv
rtl/core/hbd_match.sv
rtl/core/huffman_table_bit_decoder.sv
tb/tb_top.sv
